>>> rtl/ils_pkg.sv
// Shared types and constants for the indexed list store.
`default_nettype none

package ils_pkg;

    // Element storage depth and derived index width.
    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);

    // Field widths fixed by the request and result formats.
    localparam int TYPE_W   = 4;
    localparam int POS_W    = 7;
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    // Request codes as they arrive on the request channel.
    typedef enum logic [TYPE_W-1:0] {
        REQ_PUSH_BACK  = 4'd0,
        REQ_PUSH_FRONT = 4'd1,
        REQ_POP_BACK   = 4'd2,
        REQ_POP_FRONT  = 4'd3,
        REQ_READ       = 4'd4,
        REQ_INSERT     = 4'd5,
        REQ_DELETE     = 4'd6,
        REQ_OVERWRITE  = 4'd7,
        REQ_CLEAR      = 4'd8
    } t_req_code;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    // Decoded operation, one-hot, handed from the front end to the back end.
    typedef enum logic [9:0] {
        OP_NOP        = 10'b00_0000_0001,
        OP_PUSH_BACK  = 10'b00_0000_0010,
        OP_PUSH_FRONT = 10'b00_0000_0100,
        OP_POP_BACK   = 10'b00_0000_1000,
        OP_POP_FRONT  = 10'b00_0001_0000,
        OP_READ       = 10'b00_0010_0000,
        OP_INSERT     = 10'b00_0100_0000,
        OP_DELETE     = 10'b00_1000_0000,
        OP_OVERWRITE  = 10'b01_0000_0000,
        OP_CLEAR      = 10'b10_0000_0000
    } t_op;

    // One decoded request waiting in the queue.
    typedef struct packed {
        t_op                     op;
        logic [POS_W-1:0]        position;
        logic signed [DATA_W-1:0] value;
    } t_cmd;

    // Queue-to-back-end handshake group.
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_chan;

endpackage

`default_nettype wire

>>> rtl/ils_if.sv
// Request and result channel interfaces of the indexed list store.
`default_nettype none

interface ils_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [ils_pkg::TYPE_W-1:0]           req_type;
    logic [ils_pkg::POS_W-1:0]            position;
    logic signed [ils_pkg::DATA_W-1:0]    value;

    modport source (output valid, output req_type, output position, output value,
                    input ready);
    modport sink   (input valid, input req_type, input position, input value,
                    output ready);
endinterface

interface ils_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [ils_pkg::DATA_W-1:0]    read_value;
    logic [ils_pkg::COUNT_W-1:0]          count;
    logic [ils_pkg::STATUS_W-1:0]         status;

    modport source (output valid, output read_value, output count, output status,
                    input ready);
    modport sink   (input valid, input read_value, input count, input status,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/indexed_list_store.sv
// Top level of the indexed list store: front end, request queue and back end.
`default_nettype none

// An ordered list of up to 64 signed 32-bit values, driven by one request per
// handshake (push or pop at either end, read, insert, delete or overwrite at an
// index, clear) and answering each request with exactly one result carrying the
// read value, the new count and a status. Requests enter a two-entry queue that
// accepts one request per cycle while it has room; while results are taken,
// the back end executes one request per cycle in a row of element cells that
// shift up or down by one place in parallel, so sustained throughput is one
// request per cycle while results are taken. An accepted request passes
// through the queue and then the result register, which holds the result
// until it is taken; the queue keeps accepting requests during that time
// until it is full. Reset clears the count, the result valid flag and the
// queue; element contents are not cleared and need no clearing pass.
module indexed_list_store (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ils_req_if.sink     i_req,
    ils_rsp_if.source   o_rsp
);

    ils_pkg::t_cmd_chan w_cmd;
    logic               w_cmd_ready;

    // Request acceptance, decode and queue.
    ils_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_cmd       (w_cmd),
        .i_cmd_ready (w_cmd_ready)
    );

    // Element storage and result generation.
    ils_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_cmd_ready (w_cmd_ready),
        .o_rsp       (o_rsp)
    );

    // The reported count never exceeds the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.count <= ils_pkg::COUNT_W'(ils_pkg::CAPACITY)))
        else $error("result count exceeds capacity");

    // A full status is only reported with the list at capacity.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status == ils_pkg::ST_FULL))
            |-> (o_rsp.count == ils_pkg::COUNT_W'(ils_pkg::CAPACITY)))
        else $error("full status with list below capacity");

    // An empty status is only reported with no elements stored.
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status == ils_pkg::ST_EMPTY)) |-> (o_rsp.count == '0))
        else $error("empty status with elements stored");

    // A failed request never returns a read value.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status != ils_pkg::ST_OK)) |-> (o_rsp.read_value == '0))
        else $error("nonzero read value on a failed request");

endmodule

`default_nettype wire

>>> rtl/ils_front.sv
// Front end: accepts requests, decodes them and buffers them in a two-entry queue.
`default_nettype none

module ils_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    ils_req_if.sink             i_req,
    output ils_pkg::t_cmd_chan  o_cmd,
    input  wire logic           i_cmd_ready
);

    ils_pkg::t_cmd r_q [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_fill;
    logic [1:0]    n_fill;
    ils_pkg::t_cmd w_dec;
    logic          w_push;
    logic          w_pop;

    // Translate the request code into a one-hot operation; unused codes do nothing.
    always_comb begin
        w_dec.position = i_req.position;
        w_dec.value    = i_req.value;
        unique case (i_req.req_type)
            ils_pkg::REQ_PUSH_BACK:  w_dec.op = ils_pkg::OP_PUSH_BACK;
            ils_pkg::REQ_PUSH_FRONT: w_dec.op = ils_pkg::OP_PUSH_FRONT;
            ils_pkg::REQ_POP_BACK:   w_dec.op = ils_pkg::OP_POP_BACK;
            ils_pkg::REQ_POP_FRONT:  w_dec.op = ils_pkg::OP_POP_FRONT;
            ils_pkg::REQ_READ:       w_dec.op = ils_pkg::OP_READ;
            ils_pkg::REQ_INSERT:     w_dec.op = ils_pkg::OP_INSERT;
            ils_pkg::REQ_DELETE:     w_dec.op = ils_pkg::OP_DELETE;
            ils_pkg::REQ_OVERWRITE:  w_dec.op = ils_pkg::OP_OVERWRITE;
            ils_pkg::REQ_CLEAR:      w_dec.op = ils_pkg::OP_CLEAR;
            default:                 w_dec.op = ils_pkg::OP_NOP;
        endcase
    end

    // Queue handshakes on both sides.
    assign i_req.ready = (r_fill != 2'd2);
    assign w_push      = i_req.valid && i_req.ready;
    assign o_cmd.valid = (r_fill != 2'd0);
    assign o_cmd.cmd   = r_q[r_rd_ptr];
    assign w_pop       = o_cmd.valid && i_cmd_ready;

    always_comb begin
        n_fill = r_fill;
        if (w_push && !w_pop) begin
            n_fill = r_fill + 2'd1;
        end else if (w_pop && !w_push) begin
            n_fill = r_fill - 2'd1;
        end
    end

    // Queue pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            r_fill <= n_fill;
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_dec;
        end
    end

endmodule

`default_nettype wire

>>> rtl/ils_back.sv
// Back end: row of shifting element cells, element count and result register.
`default_nettype none

module ils_back (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire ils_pkg::t_cmd_chan  i_cmd,
    output logic                     o_cmd_ready,
    ils_rsp_if.source                o_rsp
);

    localparam int IdxW  = ils_pkg::IDX_W;
    localparam int CntW  = ils_pkg::COUNT_W;
    localparam int DataW = ils_pkg::DATA_W;

    logic [DataW-1:0]         r_cells [ils_pkg::CAPACITY];
    logic [CntW-1:0]          r_count;
    logic [CntW-1:0]          n_count;
    logic                     r_rsp_valid;
    logic signed [DataW-1:0]  r_rd_value;
    logic [CntW-1:0]          r_rsp_count;
    ils_pkg::t_status         r_status;

    ils_pkg::t_status         w_status;
    logic [DataW-1:0]         w_rd;
    logic                     w_ins;
    logic                     w_del;
    logic                     w_wr;
    logic [IdxW-1:0]          w_idx;
    logic                     w_full;
    logic                     w_empty;
    logic                     w_pos_lt;
    logic                     w_pos_le;
    logic [IdxW-1:0]          w_pos_idx;
    logic                     w_fire;

    // The back end takes a request whenever the result register is free or draining.
    assign o_cmd_ready = !r_rsp_valid || o_rsp.ready;
    assign w_fire      = i_cmd.valid && o_cmd_ready;

    assign w_full    = (r_count == CntW'(ils_pkg::CAPACITY));
    assign w_empty   = (r_count == '0);
    assign w_pos_lt  = (i_cmd.cmd.position < r_count);
    assign w_pos_le  = (i_cmd.cmd.position <= r_count);
    assign w_pos_idx = i_cmd.cmd.position[IdxW-1:0];

    // Classify the request against the current count and pick the cell operation.
    always_comb begin
        w_status = ils_pkg::ST_OK;
        n_count  = r_count;
        w_rd     = '0;
        w_ins    = 1'b0;
        w_del    = 1'b0;
        w_wr     = 1'b0;
        w_idx    = '0;
        unique case (i_cmd.cmd.op)
            ils_pkg::OP_PUSH_BACK: begin
                if (w_full) begin
                    w_status = ils_pkg::ST_FULL;
                end else begin
                    w_ins   = 1'b1;
                    w_idx   = r_count[IdxW-1:0];
                    n_count = r_count + 1'b1;
                end
            end
            ils_pkg::OP_PUSH_FRONT: begin
                if (w_full) begin
                    w_status = ils_pkg::ST_FULL;
                end else begin
                    w_ins   = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            ils_pkg::OP_POP_BACK: begin
                if (w_empty) begin
                    w_status = ils_pkg::ST_EMPTY;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            ils_pkg::OP_POP_FRONT: begin
                if (w_empty) begin
                    w_status = ils_pkg::ST_EMPTY;
                end else begin
                    w_del   = 1'b1;
                    n_count = r_count - 1'b1;
                end
            end
            ils_pkg::OP_READ: begin
                if (!w_pos_lt) begin
                    w_status = ils_pkg::ST_RANGE;
                end else begin
                    w_rd = r_cells[w_pos_idx];
                end
            end
            ils_pkg::OP_INSERT: begin
                if (!w_pos_le) begin
                    w_status = ils_pkg::ST_RANGE;
                end else if (w_full) begin
                    w_status = ils_pkg::ST_FULL;
                end else begin
                    w_ins   = 1'b1;
                    w_idx   = w_pos_idx;
                    n_count = r_count + 1'b1;
                end
            end
            ils_pkg::OP_DELETE: begin
                if (!w_pos_lt) begin
                    w_status = ils_pkg::ST_RANGE;
                end else begin
                    w_del   = 1'b1;
                    w_idx   = w_pos_idx;
                    n_count = r_count - 1'b1;
                end
            end
            ils_pkg::OP_OVERWRITE: begin
                if (!w_pos_lt) begin
                    w_status = ils_pkg::ST_RANGE;
                end else begin
                    w_wr  = 1'b1;
                    w_idx = w_pos_idx;
                end
            end
            ils_pkg::OP_CLEAR: begin
                n_count = '0;
            end
            ils_pkg::OP_NOP: begin
                n_count = r_count;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // Each cell loads the new value, its lower neighbor on insert or its upper
    // neighbor on delete.
    for (genvar gi = 0; gi < ils_pkg::CAPACITY; gi++) begin : g_cell
        logic [DataW-1:0] w_below;
        logic [DataW-1:0] w_above;

        if (gi == 0) begin : g_first
            assign w_below = r_cells[gi];
        end else begin : g_mid_lo
            assign w_below = r_cells[gi-1];
        end
        if (gi == ils_pkg::CAPACITY - 1) begin : g_last
            assign w_above = r_cells[gi];
        end else begin : g_mid_hi
            assign w_above = r_cells[gi+1];
        end

        always_ff @(posedge i_clk) begin
            if (w_fire) begin
                if ((w_ins || w_wr) && (IdxW'(gi) == w_idx)) begin
                    r_cells[gi] <= i_cmd.cmd.value;
                end else if (w_ins && (IdxW'(gi) > w_idx)) begin
                    r_cells[gi] <= w_below;
                end else if (w_del && (IdxW'(gi) >= w_idx)) begin
                    r_cells[gi] <= w_above;
                end
            end
        end
    end

    // Element count and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_count     <= n_count;
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_rd_value  <= w_rd;
            r_rsp_count <= n_count;
            r_status    <= w_status;
        end
    end

    assign o_rsp.valid      = r_rsp_valid;
    assign o_rsp.read_value = r_rd_value;
    assign o_rsp.count      = r_rsp_count;
    assign o_rsp.status     = r_status;

endmodule

`default_nettype wire
